@@ sv/morph_open_close_3x3_defines.svh @@
// ============================================================================
// Assertion macros for the morphology filter
// Shorthand for clocked implication checks, reset masked.
// ============================================================================
`ifndef MORPH_OPEN_CLOSE_3X3_DEFINES_SVH
`define MORPH_OPEN_CLOSE_3X3_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define MOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define MOC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/moc_pkg.sv @@
// ============================================================================
// moc_pkg
// Shared types and constants of the 3x3 opening and closing filter.
// ============================================================================
package moc_pkg;

    localparam int PIX_BITS     = 8;
    localparam int WIDTH_BITS   = 11;
    localparam int HEIGHT_BITS  = 13;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_BITS     = 13;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT   = 4096;
    localparam int MIN_DIM      = 3;
    localparam int WIN_SIZE     = 9;

    localparam logic [PIX_BITS-1:0] PIX_FULL  = 8'hFF;
    localparam logic [PIX_BITS-1:0] PIX_EMPTY = 8'h00;

    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [WIDTH_BITS-1:0]  RST_WIDTH  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] RST_HEIGHT = 13'd480;

    typedef struct packed {
        logic                   clear;
        logic [WIDTH_BITS-1:0]  frame_width;
        logic [HEIGHT_BITS-1:0] frame_height;
    } moc_ctl_t;

    typedef struct packed {
        logic                valid;
        logic                blank;
        logic                last;
        logic [PIX_BITS-1:0] value;
    } moc_tok_t;

endpackage

@@ sv/morph_oc_in_if.sv @@
// ============================================================================
// morph_oc_in_if
// Input pixel channel: valid, ready, action and the pixel payload.
// ============================================================================
interface morph_oc_in_if;
    import moc_pkg::*;

    logic                valid;
    logic                ready;
    logic                action;
    logic [PIX_BITS-1:0] pixel;

    modport source (output valid, output action, output pixel, input ready);
    modport sink   (input valid, input action, input pixel, output ready);
endinterface

@@ sv/morph_oc_out_if.sv @@
// ============================================================================
// morph_oc_out_if
// Result channel: valid, ready and the filtered pixel payload.
// ============================================================================
interface morph_oc_out_if;
    import moc_pkg::*;

    logic                valid;
    logic                ready;
    logic [PIX_BITS-1:0] out_pixel;
    logic                last_of_frame;

    modport source (output valid, output out_pixel, output last_of_frame, input ready);
    modport sink   (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

@@ sv/moc_stage.sv @@
// ============================================================================
// moc_stage
// One 3x3 erode or dilate stage with its two-row line memory and window.
// ============================================================================
module moc_stage
    import moc_pkg::*;
#(
    parameter int   MAX_WIDTH = MAX_WIDTH_DEF,
    parameter logic DILATE    = 1'b0
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  moc_ctl_t ctl,
    input  moc_tok_t in_tok,
    output logic     in_ready,
    output moc_tok_t out_tok,
    input  logic     out_ready
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = (AW > WIDTH_BITS) ? AW : WIDTH_BITS;
    localparam int BW = CW + 1;
    localparam int DW = 2 * PIX_BITS;

    logic [DW-1:0] mem [MAX_WIDTH];

    logic                   s_valid_reg, s_valid_next;
    logic                   s_blank_reg;
    logic [PIX_BITS-1:0]    s_pix_reg;
    logic [DW-1:0]          rd_reg;
    logic                   fwd_reg;
    logic [DW-1:0]          fwd_data_reg;
    logic [CW-1:0]          col_reg, col_next, dcol_reg, dcol_next;
    logic [HEIGHT_BITS-1:0] row_reg, row_next, drow_reg, drow_next;
    logic [BW-1:0]          backlog_reg, backlog_next;
    logic [PIX_BITS-1:0]    win_reg [WIN_SIZE];
    logic [PIX_BITS-1:0]    win_next [WIN_SIZE];

    logic [CW-1:0]          w_ext, w_last;
    logic [BW-1:0]          w_plus1;
    logic [HEIGHT_BITS-1:0] h_last;
    logic [DW-1:0]          rd;
    logic [PIX_BITS-1:0]    top, mid, op_val, res;
    logic                   full_backlog, at_start, gives, produce, pass_blank, dep, border;
    logic                   we, entry, fwd_hit;
    logic [AW-1:0]          wa, ra;
    logic [BW-1:0]          blank_off;

    assign w_ext   = CW'(ctl.frame_width);
    assign w_last  = w_ext - CW'(1);
    assign w_plus1 = BW'(w_ext) + BW'(1);
    assign h_last  = ctl.frame_height - HEIGHT_BITS'(1);

    assign rd  = fwd_reg ? fwd_data_reg : rd_reg;
    assign top = rd[DW-1:PIX_BITS];
    assign mid = rd[PIX_BITS-1:0];

    assign full_backlog = (backlog_reg == w_plus1);
    assign at_start     = (col_reg == '0) && (row_reg == '0);
    assign gives        = s_blank_reg ? (at_start && (backlog_reg != '0)) : full_backlog;
    assign produce      = s_valid_reg && gives;
    assign pass_blank   = s_valid_reg && s_blank_reg && !gives;
    assign dep          = s_valid_reg && (!(produce || pass_blank) || out_ready);
    assign in_ready     = !s_valid_reg || dep;
    assign entry        = in_tok.valid && in_ready;

    always_comb
    begin
        win_next[0] = win_reg[1];
        win_next[1] = win_reg[2];
        win_next[2] = top;
        win_next[3] = win_reg[4];
        win_next[4] = win_reg[5];
        win_next[5] = mid;
        win_next[6] = win_reg[7];
        win_next[7] = win_reg[8];
        win_next[8] = s_pix_reg;
    end

    always_comb
    begin
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            if (DILATE)
                hit = hit | (win_next[i] == PIX_FULL);
            else
                hit = hit | (win_next[i] == PIX_EMPTY);
        end
        if (DILATE)
            op_val = hit ? PIX_FULL : PIX_EMPTY;
        else
            op_val = hit ? PIX_EMPTY : PIX_FULL;
    end

    assign border = (drow_reg == '0) || (drow_reg == h_last) ||
                    (dcol_reg == '0) || (dcol_reg == w_last);

    always_comb
    begin
        if (s_blank_reg)
            res = full_backlog ? top : mid;
        else if (border)
            res = win_next[4];
        else
            res = op_val;
    end

    always_comb
    begin
        out_tok.valid = produce || pass_blank;
        out_tok.blank = pass_blank;
        out_tok.last  = (drow_reg == h_last) && (dcol_reg == w_last);
        out_tok.value = res;
    end

    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        dcol_next    = dcol_reg;
        drow_next    = drow_reg;
        backlog_next = backlog_reg;
        if (dep)
        begin
            if (!s_blank_reg)
            begin
                if (col_reg == w_last)
                begin
                    col_next = '0;
                    row_next = (row_reg == h_last) ? '0 : row_reg + HEIGHT_BITS'(1);
                end
                else
                begin
                    col_next = col_reg + CW'(1);
                end
                if (!gives)
                    backlog_next = backlog_reg + BW'(1);
            end
            else if (gives)
            begin
                backlog_next = backlog_reg - BW'(1);
            end
            if (gives)
            begin
                if (dcol_reg == w_last)
                begin
                    dcol_next = '0;
                    drow_next = (drow_reg == h_last) ? '0 : drow_reg + HEIGHT_BITS'(1);
                end
                else
                begin
                    dcol_next = dcol_reg + CW'(1);
                end
            end
        end
    end

    assign we        = dep && !s_blank_reg;
    assign wa        = col_reg[AW-1:0];
    assign blank_off = BW'(w_ext) - backlog_next;
    assign ra        = !in_tok.blank ? col_next[AW-1:0] :
                       (backlog_next == w_plus1) ? w_last[AW-1:0] : blank_off[AW-1:0];
    assign fwd_hit   = we && (wa == ra);
    assign s_valid_next = entry || (s_valid_reg && !dep);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= {mid, s_pix_reg};
        if (entry)
            rd_reg <= mem[ra];
    end

    always_ff @(posedge clk)
    begin
        if (entry)
        begin
            s_blank_reg  <= in_tok.blank;
            s_pix_reg    <= in_tok.value;
            fwd_data_reg <= {mid, s_pix_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            dcol_reg    <= '0;
            drow_reg    <= '0;
            backlog_reg <= '0;
            for (int i = 0; i < WIN_SIZE; i++)
                win_reg[i] <= '0;
        end
        else if (ctl.clear)
        begin
            s_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            col_reg     <= '0;
            row_reg     <= '0;
            dcol_reg    <= '0;
            drow_reg    <= '0;
            backlog_reg <= '0;
            for (int i = 0; i < WIN_SIZE; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            s_valid_reg <= s_valid_next;
            if (entry)
                fwd_reg <= fwd_hit;
            col_reg     <= col_next;
            row_reg     <= row_next;
            dcol_reg    <= dcol_next;
            drow_reg    <= drow_next;
            backlog_reg <= backlog_next;
            if (we)
                for (int i = 0; i < WIN_SIZE; i++)
                    win_reg[i] <= win_next[i];
        end
    end

endmodule

@@ sv/morph_open_close_3x3.sv @@
// ============================================================================
// morph_open_close_3x3
// Streamed 3x3 opening then closing: erode, dilate, dilate, erode.
// ============================================================================
//  Channel   Dir  Payload                       Handshake
//  in_ch     in   action, pixel                 valid/ready
//  out_ch    out  out_pixel, last_of_frame      valid/ready
//  cfg       in   cfg_index, cfg_data           cfg_we, no wait
//
// One beat per clock is sustained while the output accepts; each stage holds
// one beat and reads its line memory as the beat enters, so a result lags its
// pixel by four times (frame_width + 1) beats. Reset clears all control state;
// the line memories are not cleared. A stalled output holds the pipeline only
// as far back as the first free stage slot.
`include "morph_open_close_3x3_defines.svh"

module morph_open_close_3x3
    import moc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    morph_oc_in_if.sink             in_ch,
    morph_oc_out_if.source          out_ch
);

    localparam int NSTAGE = 4;
    localparam logic [NSTAGE-1:0] DILATE_MAP = 4'b0110;

    logic [WIDTH_BITS-1:0]  width_reg, width_next;
    logic [HEIGHT_BITS-1:0] height_reg, height_next;
    logic                   clear_next;
    moc_ctl_t               ctl;
    moc_tok_t               tok [NSTAGE+1];
    logic                   rdy [NSTAGE+1];
    logic                   out_valid_reg;
    logic [PIX_BITS-1:0]    out_pixel_reg;
    logic                   out_last_reg;
    logic                   out_free;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        clear_next  = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:
                begin
                    clear_next = 1'b1;
                    if (cfg_data[WIDTH_BITS-1:0] < WIDTH_BITS'(MIN_DIM))
                        width_next = WIDTH_BITS'(MIN_DIM);
                    else if (int'(cfg_data[WIDTH_BITS-1:0]) > MAX_WIDTH)
                        width_next = WIDTH_BITS'(MAX_WIDTH);
                    else
                        width_next = cfg_data[WIDTH_BITS-1:0];
                end
                CFG_FRAME_HEIGHT:
                begin
                    clear_next = 1'b1;
                    if (cfg_data < HEIGHT_BITS'(MIN_DIM))
                        height_next = HEIGHT_BITS'(MIN_DIM);
                    else if (cfg_data > HEIGHT_BITS'(MAX_HEIGHT))
                        height_next = HEIGHT_BITS'(MAX_HEIGHT);
                    else
                        height_next = cfg_data;
                end
                default:
                begin
                    clear_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign ctl.clear        = clear_next;
    assign ctl.frame_width  = width_reg;
    assign ctl.frame_height = height_reg;

    always_comb
    begin
        tok[0].valid = in_ch.valid;
        tok[0].blank = in_ch.action;
        tok[0].last  = 1'b0;
        tok[0].value = in_ch.pixel;
    end
    assign in_ch.ready = rdy[0];

    for (genvar k = 0; k < NSTAGE; k++)
    begin : g_stage
        moc_stage #(
            .MAX_WIDTH (MAX_WIDTH),
            .DILATE    (DILATE_MAP[k])
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .in_tok    (tok[k]),
            .in_ready  (rdy[k]),
            .out_tok   (tok[k+1]),
            .out_ready (rdy[k+1])
        );
    end

    assign out_free     = !out_valid_reg || out_ch.ready;
    assign rdy[NSTAGE]  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (clear_next)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= tok[NSTAGE].valid && !tok[NSTAGE].blank;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_pixel_reg <= tok[NSTAGE].value;
            out_last_reg  <= tok[NSTAGE].last;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_pixel     = out_pixel_reg;
    assign out_ch.last_of_frame = out_last_reg;

    `MOC_ASSERT_NEXT(a_cfg_flushes_output, clk, rst_n, clear_next, !out_valid_reg, "result beat survived a register write")
    `MOC_ASSERT_NEXT(a_result_captured, clk, rst_n, tok[NSTAGE].valid && !tok[NSTAGE].blank && out_free && !clear_next, out_valid_reg, "final stage result was lost")
    `MOC_ASSERT_SAME(a_width_in_range, clk, rst_n, 1'b1, width_reg >= WIDTH_BITS'(MIN_DIM) && height_reg >= HEIGHT_BITS'(MIN_DIM), "frame size below minimum")

endmodule

@@ tb/moc_checker.sv @@
// ----------------------------------------------------------------------------
// moc_checker
// Watches the configuration port and both channels of the opening and closing
// filter, predicts every filtered pixel from the accepted input beats and
// compares each output beat with the oldest prediction.
// ----------------------------------------------------------------------------
module moc_checker
    import moc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    morph_oc_in_if                  in_mon,
    morph_oc_out_if                 out_mon,
    output int                      errors,
    output int                      owed,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MW = MAX_WIDTH_DEF;

    typedef struct packed {
        logic [PIX_BITS-1:0] pix;
        logic                last;
    } filtered_t;

    logic [PIX_BITS-1:0] row_mem [0:8*MW-1];
    logic [PIX_BITS-1:0] win [0:35];
    int unsigned         pos [4];
    int unsigned         drain [4];
    int unsigned         blog [4];
    int unsigned         fw;
    int unsigned         fh;
    filtered_t           filtered_q [$];
    int                  err_cnt;

    function automatic void clear_pipe();
        for (int i = 0; i < 36; i++)
        begin
            win[i] = PIX_EMPTY;
        end
        for (int k = 0; k < 4; k++)
        begin
            pos[k]   = 0;
            drain[k] = 0;
            blog[k]  = 0;
        end
    endfunction

    function automatic logic [PIX_BITS-1:0] morph_op(int base, bit dil);
        for (int i = 0; i < WIN_SIZE; i++)
        begin
            if (dil && win[base+i] == PIX_FULL)
                return PIX_FULL;
            if (!dil && win[base+i] == PIX_EMPTY)
                return PIX_EMPTY;
        end
        return dil ? PIX_EMPTY : PIX_FULL;
    endfunction

    function automatic bit stage_pixel(int k, logic [PIX_BITS-1:0] v, bit dil,
                                       output logic [PIX_BITS-1:0] ov,
                                       output int unsigned q);
        int unsigned n, p, col, row, c, b0, b1, base;
        logic [PIX_BITS-1:0] top, mid;
        n    = fw * fh;
        p    = pos[k];
        col  = p % fw;
        b0   = k * 2 * MW;
        b1   = b0 + MW;
        base = k * 9;
        top  = row_mem[b1+col];
        mid  = row_mem[b0+col];
        ov   = PIX_EMPTY;
        q    = 0;
        row_mem[b1+col] = mid;
        row_mem[b0+col] = v;
        for (int r = 0; r < 3; r++)
        begin
            win[base+r*3]   = win[base+r*3+1];
            win[base+r*3+1] = win[base+r*3+2];
        end
        win[base+2] = top;
        win[base+5] = mid;
        win[base+8] = v;
        pos[k] = (p + 1 == n) ? 0 : p + 1;
        blog[k]++;
        if (blog[k] <= fw + 1)
            return 0;
        q   = drain[k];
        row = q / fw;
        c   = q % fw;
        if (row == 0 || row == fh - 1 || c == 0 || c == fw - 1)
            ov = win[base+4];
        else
            ov = morph_op(base, dil);
        drain[k] = (q + 1 == n) ? 0 : q + 1;
        blog[k]--;
        return 1;
    endfunction

    function automatic bit stage_blank(int k, output logic [PIX_BITS-1:0] ov,
                                       output int unsigned q);
        int unsigned n, j, b0, b1;
        n  = fw * fh;
        b0 = k * 2 * MW;
        b1 = b0 + MW;
        ov = PIX_EMPTY;
        q  = 0;
        if (pos[k] != 0 || blog[k] == 0 || blog[k] > fw + 1)
            return 0;
        j  = fw + 1 - blog[k];
        ov = (j == 0) ? row_mem[b1+fw-1] : row_mem[b0+j-1];
        q  = drain[k];
        drain[k] = (q + 1 == n) ? 0 : q + 1;
        blog[k]--;
        return 1;
    endfunction

    function automatic void predict_beat(logic blank, logic [PIX_BITS-1:0] pixel);
        bit                  is_pix, got;
        logic [PIX_BITS-1:0] v, ov;
        int unsigned         q;
        filtered_t           res;
        is_pix = !blank;
        v      = pixel;
        q      = 0;
        for (int k = 0; k < 4; k++)
        begin
            if (is_pix)
                got = stage_pixel(k, v, (k == 1 || k == 2), ov, q);
            else
                got = stage_blank(k, ov, q);
            if (is_pix && !got)
                return;
            if (got)
            begin
                v      = ov;
                is_pix = 1;
            end
        end
        if (!is_pix)
            return;
        res.pix  = v;
        res.last = (q == fw * fh - 1);
        filtered_q.push_back(res);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        err_cnt++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t   want;
        int unsigned v;
        int          sum;
        if (!rst_n)
        begin
            fw = RST_WIDTH;
            fh = RST_HEIGHT;
            for (int i = 0; i < 8 * MW; i++)
            begin
                row_mem[i] = PIX_EMPTY;
            end
            clear_pipe();
            filtered_q.delete();
            err_cnt = 0;
            errors  <= 0;
            owed    <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FRAME_WIDTH)
                begin
                    v  = cfg_data[WIDTH_BITS-1:0];
                    fw = (v < MIN_DIM) ? MIN_DIM : (v > MW) ? MW : v;
                    clear_pipe();
                end
                else if (cfg_index == CFG_FRAME_HEIGHT)
                begin
                    v  = cfg_data[HEIGHT_BITS-1:0];
                    fh = (v < MIN_DIM) ? MIN_DIM : (v > MAX_HEIGHT) ? MAX_HEIGHT : v;
                    clear_pipe();
                end
            end
            if (in_mon.valid && in_mon.ready)
                predict_beat(in_mon.action, in_mon.pixel);
            if (out_mon.valid && out_mon.ready)
            begin
                if (filtered_q.size() == 0)
                    report_mismatch("unexpected beat, pixel", out_mon.out_pixel, -1);
                else
                begin
                    want = filtered_q.pop_front();
                    if (out_mon.out_pixel !== want.pix)
                        report_mismatch("out_pixel", out_mon.out_pixel, want.pix);
                    if (out_mon.last_of_frame !== want.last)
                        report_mismatch("last_of_frame", out_mon.last_of_frame, want.last);
                end
            end
            sum = 0;
            for (int k = 0; k < 4; k++)
            begin
                sum += blog[k];
            end
            errors  <= err_cnt;
            owed    <= sum;
            pending <= filtered_q.size();
        end
    end
endmodule

@@ tb/tb_morph_open_close_3x3.sv @@
// ----------------------------------------------------------------------------
// tb_morph_open_close_3x3
// Drives frames of pixels and flushing blanks into the filter under several
// frame sizes and stall patterns; a checker beside the block predicts and
// compares every output beat.
// ----------------------------------------------------------------------------
module tb_morph_open_close_3x3;
    import moc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;

    logic                    clk = 0;
    logic                    rst_n = 0;
    logic                    cfg_we = 0;
    logic [CFG_IDX_BITS-1:0] cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_BITS-1:0]     cfg_data = '0;
    int                      errors, owed, pending;
    int                      tx_idle = 0;
    int                      rx_stall = 0;
    int                      cycles = 0;
    int                      pix_sent = 0;

    morph_oc_in_if  in_if ();
    morph_oc_out_if out_if ();

    morph_open_close_3x3 i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_if),
        .out_ch    (out_if)
    );

    moc_checker i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_mon    (in_if),
        .out_mon   (out_if),
        .errors    (errors),
        .owed      (owed),
        .pending   (pending)
    );

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    always @(posedge clk)
    begin
        out_if.ready <= ($urandom_range(99) >= rx_stall);
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_beat(logic blank, logic [PIX_BITS-1:0] pix);
        while ($urandom_range(99) < tx_idle)
        begin
            in_if.valid <= 1'b0;
            @(posedge clk);
        end
        in_if.valid  <= 1'b1;
        in_if.action <= blank;
        in_if.pixel  <= pix;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        if (!blank)
            pix_sent++;
    endtask

    task automatic go_quiet();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || owed != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Content: 0 all dark, 1 all bright, 2 sparse bright, 3 dense bright,
    // 4 arbitrary grey, 5 binary with noise blanks inside the frame.
    task automatic send_frame(int w, int h, int kind);
        logic [PIX_BITS-1:0] p;
        for (int i = 0; i < w * h; i++)
        begin
            case (kind)
                0: p = PIX_EMPTY;
                1: p = PIX_FULL;
                2: p = ($urandom_range(99) < 20) ? PIX_FULL : PIX_EMPTY;
                3: p = ($urandom_range(99) < 80) ? PIX_FULL : PIX_EMPTY;
                4: p = PIX_BITS'($urandom_range(255));
                default: p = $urandom_range(1) ? PIX_FULL : PIX_EMPTY;
            endcase
            if (kind == 5 && $urandom_range(99) < 10)
                send_beat(1'b1, PIX_BITS'($urandom_range(255)));
            send_beat(1'b0, p);
        end
    endtask

    task automatic flush_tail();
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (owed != 0)
            send_beat(1'b1, PIX_BITS'($urandom_range(255)));
        go_quiet();
    endtask

    task automatic random_phase(int quota);
        int w, h, goal;
        goal = pix_sent + quota;
        while (pix_sent < goal)
        begin
            if ($urandom_range(2) == 0)
            begin
                w = ($urandom_range(9) == 0) ? $urandom_range(2047) : $urandom_range(3, 10);
                h = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(3, 6);
                write_reg(CFG_FRAME_WIDTH, CFG_BITS'(w));
                write_reg(CFG_FRAME_HEIGHT, CFG_BITS'(h));
                if (w > 30)
                    write_reg(CFG_FRAME_WIDTH, CFG_BITS'($urandom_range(3, 10)));
            end
            w = i_checker.fw;
            h = i_checker.fh;
            repeat ($urandom_range(1, 2))
                send_frame(w, h, $urandom_range(5));
            flush_tail();
        end
    endtask

    initial
    begin
        in_if.valid  = 1'b0;
        in_if.action = 1'b0;
        in_if.pixel  = '0;
        out_if.ready = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        tx_idle  = 15;
        rx_stall = 59;
        write_reg(CFG_FRAME_WIDTH, CFG_BITS'(0));
        write_reg(CFG_FRAME_HEIGHT, CFG_BITS'(2));
        write_reg(2'd2, 13'h1FFF);
        write_reg(2'd3, 13'h0AAA);
        send_frame(3, 3, 0);
        send_frame(3, 3, 1);
        flush_tail();
        send_beat(1'b1, 8'hA5);
        send_frame(3, 3, 4);
        flush_tail();
        random_phase(270);

        tx_idle  = 59;
        rx_stall = 15;
        random_phase(270);

        tx_idle  = 0;
        rx_stall = 0;
        write_reg(CFG_FRAME_WIDTH, 13'h07FF);
        write_reg(CFG_FRAME_HEIGHT, 13'h1FFF);
        write_reg(CFG_FRAME_WIDTH, CFG_BITS'(20));
        write_reg(CFG_FRAME_HEIGHT, CFG_BITS'(5));
        send_frame(20, 5, 5);
        flush_tail();
        random_phase(270);

        go_quiet();
        if (errors == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+sv
sv/moc_pkg.sv
sv/morph_oc_in_if.sv
sv/morph_oc_out_if.sv
sv/moc_stage.sv
sv/morph_open_close_3x3.sv
tb/moc_checker.sv
tb/tb_morph_open_close_3x3.sv
